/* hw/rtl/lnle_pkg.sv */
package lnle_pkg;

	// Longest login name the line buffer holds.
	localparam int NAME_LEN = 16;
	localparam int CNT_W    = $clog2(NAME_LEN + 1);
	localparam int IDX_W    = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NAME_LEN);

	// Depth of the command queue between front and back end (a power of two).
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	localparam int CHAR_W = 7;
	localparam int LEN_W  = 5;

	localparam logic [CHAR_W-1:0] CH_CR       = 7'd13;
	localparam logic [CHAR_W-1:0] CH_LF       = 7'd10;
	localparam logic [CHAR_W-1:0] CH_NUL      = 7'd0;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;
	localparam logic [CHAR_W-1:0] ERASE_RESET = 7'd35;
	localparam logic [CHAR_W-1:0] KILL_RESET  = 7'd64;

	// Configuration register indexes.
	localparam logic REG_ERASE = 1'b0;
	localparam logic REG_KILL  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_NAME  = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_BREAK = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_STORE,
		OP_ERASE,
		OP_KILL,
		OP_CR,
		OP_LF,
		OP_BREAK
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        raw;
		logic [CHAR_W-1:0] ch;
		logic              set_upper;
		logic              set_lower;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data_byte;
		logic [LEN_W-1:0]  name_length;
		logic              saw_cr;
		logic              saw_upper;
		logic              saw_lower;
		logic              last_of_run;
	} item_t;

	// The length field is five bits wide whatever the buffer size.
	function automatic logic [LEN_W-1:0] len_field(input logic [CNT_W-1:0] cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		return wide[LEN_W-1:0];
	endfunction

endpackage

/* hw/rtl/lnle_in_if.sv */
interface lnle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/lnle_out_if.sv */
interface lnle_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [4:0] name_length;
	logic       saw_cr;
	logic       saw_upper;
	logic       saw_lower;
	logic       last_of_run;

	modport source (output valid, output kind, output data_byte, output name_length,
		output saw_cr, output saw_upper, output saw_lower, output last_of_run,
		input ready);
	modport sink (input valid, input kind, input data_byte, input name_length,
		input saw_cr, input saw_upper, input saw_lower, input last_of_run,
		output ready);
endinterface

/* hw/rtl/login_name_line_editor.sv */
// Login name line editor.
// byte_chan carries one received terminal byte per request (bit 7 is parity
// and is ignored for classification). result_chan returns the results of
// each request in order: echoes, name characters, a completion item with
// the name length and case and CR flags, or a break item; last_of_run marks
// the final result of a request. Both channels use valid/ready and move a
// request at a clock edge where both are high.
// The user sets the erase and kill characters through the write port (wr_en,
// wr_index, wr_data) only while the block is idle; the block does not check it.
// Each request passes through the command queue and then the back end's
// output register before its first result is shown. A request causes from
// one result (break, erase, kill, stored character) up to NAME_LEN + 3 when a
// name completes; the single output register of the back end shows them in turn.
// A two-entry command queue sits between classifier and back end, so the
// input stays ready while a result waits to be taken.
// Reset (arst_n low) empties the line and the queue and sets the erase and
// kill characters to '#' and '@'. When the receiver stalls, the output item
// holds, the back end waits, and once the queue is full the input drops ready.
module login_name_line_editor (
	input  logic         clk,
	input  logic         arst_n,
	lnle_in_if.sink      byte_chan,
	lnle_out_if.source   result_chan,
	input  logic         wr_en,
	input  logic         wr_index,
	input  logic [6:0]   wr_data
);
	import lnle_pkg::*;

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    pop_cmd;
	q_stat_t q_stat;

	// Front end: holds the edit characters and classifies each byte.
	lnle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_chan (byte_chan),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.q_stat    (q_stat),
		.push      (push),
		.cmd       (push_cmd)
	);

	// Short queue so the classifier and the result sequencer stall apart.
	lnle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	// Back end: owns the line buffer and flags and emits the results.
	lnle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (pop_cmd),
		.q_stat      (q_stat),
		.pop         (pop),
		.result_chan (result_chan)
	);

	// The back end only takes a command that the queue really holds.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("command taken from an empty queue");

	// A completion item always closes its run and carries no character.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_chan.valid && result_chan.kind == KIND_DONE)
		|-> (result_chan.last_of_run && result_chan.data_byte == 8'd0))
		else $error("completion item malformed");

	// Name characters are 7-bit values, with letters in lowercase, and never end a run.
	a_name_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_chan.valid && result_chan.kind == KIND_NAME)
		|-> (!result_chan.last_of_run && !result_chan.data_byte[7]))
		else $error("name character item malformed");

	// The reported length never exceeds the buffer.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_chan.valid |-> (32'(result_chan.name_length) <= NAME_LEN))
		else $error("name length beyond buffer size");

endmodule

/* hw/rtl/lnle_front.sv */
module lnle_front (
	input  logic                     clk,
	input  logic                     arst_n,
	lnle_in_if.sink                  byte_chan,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [6:0]               wr_data,
	input  lnle_pkg::q_stat_t        q_stat,
	output logic                     push,
	output lnle_pkg::cmd_t           cmd
);
	import lnle_pkg::*;

	logic [CHAR_W-1:0] erase_q;
	logic [CHAR_W-1:0] kill_q;
	logic [CHAR_W-1:0] c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q <= ERASE_RESET;
			kill_q  <= KILL_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ERASE: erase_q <= wr_data;
				REG_KILL:  kill_q  <= wr_data;
				default:   ;
			endcase
		end
	end

	assign byte_chan.ready = !q_stat.full;
	assign push            = byte_chan.valid && !q_stat.full;
	assign c               = byte_chan.rx_byte[6:0];

	// Letters are tested before the edit characters, so a letter chosen as
	// erase or kill is still stored.
	always_comb begin
		cmd.raw       = byte_chan.rx_byte;
		cmd.ch        = c;
		cmd.set_upper = 1'b0;
		cmd.set_lower = 1'b0;
		cmd.op        = OP_STORE;
		if (c == CH_NUL) begin
			cmd.op = OP_BREAK;
		end else if (c >= 7'd97 && c <= 7'd122) begin
			cmd.set_lower = 1'b1;
		end else if (c >= 7'd65 && c <= 7'd90) begin
			cmd.set_upper = 1'b1;
			cmd.ch        = c + CASE_OFFSET;
		end else if (c == erase_q) begin
			cmd.op = OP_ERASE;
		end else if (c == kill_q) begin
			cmd.op = OP_KILL;
		end else if (c == CH_CR) begin
			cmd.op = OP_CR;
		end else if (c == CH_LF) begin
			cmd.op = OP_LF;
		end
	end

endmodule

/* hw/rtl/lnle_queue.sv */
module lnle_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lnle_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output lnle_pkg::cmd_t     pop_cmd,
	output lnle_pkg::q_stat_t  q_stat
);
	import lnle_pkg::*;

	cmd_t               entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_cmd      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/lnle_back.sv */
module lnle_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lnle_pkg::cmd_t     cmd,
	input  lnle_pkg::q_stat_t  q_stat,
	output logic               pop,
	lnle_out_if.source         result_chan
);
	import lnle_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXTRA,
		ST_NAME,
		ST_DONE
	} state_t;

	state_t            state_q;
	item_t             item_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  fill_q;
	logic              upper_q;
	logic              lower_q;
	logic              cr_q;
	logic [CHAR_W-1:0] extra_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [CHAR_W-1:0] name_store [NAME_LEN];
	logic              load;
	logic              fire;
	logic              store_we;
	logic              has_room;

	function automatic item_t make_item(input kind_t k, input logic [7:0] d,
		input logic [LEN_W-1:0] len, input logic cr, input logic up, input logic lo,
		input logic last);
		item_t it;
		it.kind        = k;
		it.data_byte   = d;
		it.name_length = len;
		it.saw_cr      = cr;
		it.saw_upper   = up;
		it.saw_lower   = lo;
		it.last_of_run = last;
		return it;
	endfunction

	assign load     = !out_valid_q || result_chan.ready;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty && load;
	// A new item enters the output register in this cycle.
	assign fire     = (state_q == ST_IDLE) ? pop : load;
	assign has_room = (fill_q < FULL_CNT);
	assign store_we = pop && (cmd.op == OP_STORE) && has_room;

	assign result_chan.valid       = out_valid_q;
	assign result_chan.kind        = item_q.kind;
	assign result_chan.data_byte   = item_q.data_byte;
	assign result_chan.name_length = item_q.name_length;
	assign result_chan.saw_cr      = item_q.saw_cr;
	assign result_chan.saw_upper   = item_q.saw_upper;
	assign result_chan.saw_lower   = item_q.saw_lower;
	assign result_chan.last_of_run = item_q.last_of_run;

	always_ff @(posedge clk) begin
		if (store_we) begin
			name_store[fill_q[IDX_W-1:0]] <= cmd.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
			upper_q     <= 1'b0;
			lower_q     <= 1'b0;
			cr_q        <= 1'b0;
			extra_q     <= '0;
			rd_idx_q    <= '0;
		end else begin
			out_valid_q <= fire || (out_valid_q && !result_chan.ready);
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (cmd.op == OP_BREAK) begin
							item_q  <= make_item(KIND_BREAK, 8'd0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
							fill_q  <= '0;
							upper_q <= 1'b0;
							lower_q <= 1'b0;
						end else begin
							upper_q <= upper_q | cmd.set_upper;
							lower_q <= lower_q | cmd.set_lower;
							case (cmd.op)
								OP_ERASE: begin
									item_q <= make_item(KIND_ECHO, cmd.raw, '0, 1'b0, 1'b0, 1'b0,
										1'b1);
									if (fill_q != '0) begin
										fill_q <= fill_q - 1'b1;
									end
								end
								OP_KILL: begin
									item_q <= make_item(KIND_ECHO, cmd.raw, '0, 1'b0, 1'b0, 1'b0,
										1'b1);
									fill_q <= '0;
								end
								OP_CR: begin
									item_q  <= make_item(KIND_ECHO, cmd.raw, '0, 1'b0, 1'b0, 1'b0,
										1'b0);
									extra_q <= CH_LF;
									cr_q    <= 1'b1;
									state_q <= ST_EXTRA;
								end
								OP_LF: begin
									item_q  <= make_item(KIND_ECHO, cmd.raw, '0, 1'b0, 1'b0, 1'b0,
										1'b0);
									extra_q <= CH_CR;
									cr_q    <= 1'b0;
									state_q <= ST_EXTRA;
								end
								default: begin
									if (has_room) begin
										item_q <= make_item(KIND_ECHO, cmd.raw, '0, 1'b0, 1'b0,
											1'b0, 1'b1);
										fill_q <= fill_q + 1'b1;
									end else begin
										// Full buffer: drop the character and complete.
										item_q  <= make_item(KIND_ECHO, cmd.raw, '0, 1'b0, 1'b0,
											1'b0, 1'b0);
										extra_q <= CH_CR;
										cr_q    <= 1'b0;
										state_q <= ST_EXTRA;
									end
								end
							endcase
						end
					end
				end
				ST_EXTRA: begin
					if (load) begin
						item_q      <= make_item(KIND_ECHO, {1'b0, extra_q}, '0, 1'b0, 1'b0,
							1'b0, 1'b0);
						rd_idx_q    <= '0;
						state_q     <= (fill_q == '0) ? ST_DONE : ST_NAME;
					end
				end
				ST_NAME: begin
					if (load) begin
						item_q      <= make_item(KIND_NAME, {1'b0, name_store[rd_idx_q]}, '0,
							1'b0, 1'b0, 1'b0, 1'b0);
						rd_idx_q    <= rd_idx_q + 1'b1;
						if ((CNT_W'(rd_idx_q) + 1'b1) == fill_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (load) begin
						item_q      <= make_item(KIND_DONE, 8'd0, len_field(fill_q), cr_q,
							upper_q, lower_q, 1'b1);
						fill_q      <= '0;
						upper_q     <= 1'b0;
						lower_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/lnle_name_checker.sv */
// Watches both channels and the write port, keeps its own copy of the line
// state and of the erase and kill characters, and compares every result
// taken from the block against the oldest one still awaited.
module lnle_name_checker
	import lnle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lnle_in_if         byte_mon,
	lnle_out_if        result_mon,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [6:0] wr_data,
	output int         fail_count,
	output int         outstanding,
	output int         results_checked,
	output int         names_done
);

	item_t             awaited_items[$];
	item_t             held;
	bit                have_held;
	logic [CHAR_W-1:0] line_chars [NAME_LEN];
	int                line_fill;
	logic              upper_flag;
	logic              lower_flag;
	logic [CHAR_W-1:0] erase_sel;
	logic [CHAR_W-1:0] kill_sel;
	int                faults;
	int                checked;
	int                completed;

	// The newest result of a request is held back so that the last one can
	// be marked before it joins the queue.
	task automatic note_result(input kind_t k, input logic [7:0] d, input int len,
		input logic cr, input logic up, input logic lo);
		if (have_held)
			awaited_items.push_back(held);
		held.kind        = k;
		held.data_byte   = d;
		held.name_length = LEN_W'(len);
		held.saw_cr      = cr;
		held.saw_upper   = up;
		held.saw_lower   = lo;
		held.last_of_run = 1'b0;
		have_held        = 1'b1;
	endtask

	task automatic close_name(input logic cr);
		for (int i = 0; i < line_fill && i < NAME_LEN; i++)
			note_result(KIND_NAME, {1'b0, line_chars[i]}, 0, 1'b0, 1'b0, 1'b0);
		note_result(KIND_DONE, 8'd0, line_fill, cr, upper_flag, lower_flag);
		line_fill  = 0;
		upper_flag = 1'b0;
		lower_flag = 1'b0;
	endtask

	task automatic predict_line_byte(input logic [7:0] rx);
		logic [CHAR_W-1:0] ch;
		bit                keep;
		ch        = rx[CHAR_W-1:0];
		keep      = 1'b1;
		have_held = 1'b0;
		if (ch == CH_NUL) begin
			line_fill  = 0;
			upper_flag = 1'b0;
			lower_flag = 1'b0;
			note_result(KIND_BREAK, 8'd0, 0, 1'b0, 1'b0, 1'b0);
		end else begin
			note_result(KIND_ECHO, rx, 0, 1'b0, 1'b0, 1'b0);
			// Letters are tested first, so a letter chosen as erase or kill is stored.
			if (ch >= "a" && ch <= "z") begin
				lower_flag = 1'b1;
			end else if (ch >= "A" && ch <= "Z") begin
				upper_flag = 1'b1;
				ch = ch + CASE_OFFSET;
			end else if (ch == erase_sel) begin
				if (line_fill > 0)
					line_fill--;
				keep = 1'b0;
			end else if (ch == kill_sel) begin
				line_fill = 0;
				keep = 1'b0;
			end
			if (keep) begin
				if (ch == CH_CR) begin
					note_result(KIND_ECHO, {1'b0, CH_LF}, 0, 1'b0, 1'b0, 1'b0);
					close_name(1'b1);
				end else if (ch == CH_LF) begin
					note_result(KIND_ECHO, {1'b0, CH_CR}, 0, 1'b0, 1'b0, 1'b0);
					close_name(1'b0);
				end else if (line_fill >= NAME_LEN) begin
					// The character that does not fit is dropped and the name ends.
					note_result(KIND_ECHO, {1'b0, CH_CR}, 0, 1'b0, 1'b0, 1'b0);
					close_name(1'b0);
				end else begin
					line_chars[line_fill] = ch;
					line_fill++;
				end
			end
		end
		held.last_of_run = 1'b1;
		awaited_items.push_back(held);
	endtask

	task automatic check_result();
		item_t got;
		item_t want;
		got.kind        = kind_t'(result_mon.kind);
		got.data_byte   = result_mon.data_byte;
		got.name_length = result_mon.name_length;
		got.saw_cr      = result_mon.saw_cr;
		got.saw_upper   = result_mon.saw_upper;
		got.saw_lower   = result_mon.saw_lower;
		got.last_of_run = result_mon.last_of_run;
		checked++;
		if (awaited_items.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("%0t: result with nothing awaited: kind %0d data %02h len %0d",
					$realtime, got.kind, got.data_byte, got.name_length);
		end else begin
			want = awaited_items.pop_front();
			if (want.kind == KIND_DONE)
				completed++;
			if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
				got.name_length !== want.name_length || got.saw_cr !== want.saw_cr ||
				got.saw_upper !== want.saw_upper || got.saw_lower !== want.saw_lower ||
				got.last_of_run !== want.last_of_run) begin
				faults++;
				if (faults <= 10) begin
					$display("%0t: expected kind %0d data %02h len %0d cr %0b up %0b lo %0b last %0b",
						$realtime, want.kind, want.data_byte, want.name_length,
						want.saw_cr, want.saw_upper, want.saw_lower, want.last_of_run);
					$display("%0t:      got kind %0d data %02h len %0d cr %0b up %0b lo %0b last %0b",
						$realtime, got.kind, got.data_byte, got.name_length,
						got.saw_cr, got.saw_upper, got.saw_lower, got.last_of_run);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_items.delete();
			have_held       = 1'b0;
			line_fill       = 0;
			upper_flag      = 1'b0;
			lower_flag      = 1'b0;
			erase_sel       = ERASE_RESET;
			kill_sel        = KILL_RESET;
			faults          = 0;
			checked         = 0;
			completed       = 0;
			fail_count      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
			names_done      <= 0;
		end else begin
			// Results are checked before this edge's request is predicted, since
			// no result can belong to a request accepted at the same edge.
			if (result_mon.valid && result_mon.ready)
				check_result();
			if (byte_mon.valid && byte_mon.ready)
				predict_line_byte(byte_mon.rx_byte);
			if (wr_en) begin
				if (wr_index == REG_ERASE)
					erase_sel = wr_data;
				else if (wr_index == REG_KILL)
					kill_sel = wr_data;
			end
			fail_count      <= faults;
			outstanding     <= awaited_items.size();
			results_checked <= checked;
			names_done      <= completed;
		end
	end

endmodule

/* tb/tb.sv */
// Top of the line editor testbench. It makes the stimulus only: terminal
// bytes on the input channel, random back-pressure on the result channel and
// erase/kill character writes between phases. All prediction and comparison
// happens in the checker instantiated beside the block.
module tb;
	import lnle_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	logic       wr_index;
	logic [6:0] wr_data;

	lnle_in_if  byte_chan ();
	lnle_out_if result_chan ();

	int         fail_count;
	int         outstanding;
	int         results_checked;
	int         names_done;

	// The erase and kill characters currently programmed, so that well-formed
	// names can include them.
	logic [6:0] erase_now = ERASE_RESET;
	logic [6:0] kill_now  = KILL_RESET;
	int         bytes_sent;
	int         settings_used;
	int         stall_left;
	bit         calm;

	// Opening requests under the reset characters: breaks with and without
	// parity, an erase on an empty line, both cases of letter, an erase with the
	// parity bit set, a kill without it, the top and bottom non-zero characters,
	// and names ended by CR and by LF (the latter empty).
	logic [7:0] opening_bytes [12] = '{8'h00, 8'h80, 8'h23, 8'hC1, 8'h7A, 8'hA3,
		8'h5A, 8'h40, 8'hFF, 8'h01, 8'h8D, 8'h0A};

	login_name_line_editor DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_chan   (byte_chan),
		.result_chan (result_chan),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	lnle_name_checker name_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_mon        (byte_chan),
		.result_mon      (result_chan),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.names_done      (names_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] with_parity(input logic [6:0] c);
		return {1'($urandom_range(0, 1)), c};
	endfunction

	// Name characters lean towards letters, with digits and any other
	// non-zero character mixed in.
	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return with_parity(7'("a" + $urandom_range(0, 25)));
		else if (r < 7)
			return with_parity(7'("A" + $urandom_range(0, 25)));
		else if (r < 8)
			return with_parity(7'("0" + $urandom_range(0, 9)));
		else
			return with_parity(7'($urandom_range(1, 127)));
	endfunction

	// The receiver stalls in random stretches; while a calm stretch is running no
	// new stall starts, and once a running stall ends it takes every result at once.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_chan.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			result_chan.ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			result_chan.ready <= 1'b1;
		end
	end

	// Offers one byte and returns at the edge where it is accepted. Valid is
	// left high, so back-to-back requests only change the data.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			byte_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_chan.valid   <= 1'b1;
		byte_chan.rx_byte <= b;
		do @(posedge clk); while (!byte_chan.ready);
		bytes_sent++;
	endtask

	// Withdraws the input and waits until every awaited result has been taken.
	task automatic settle();
		byte_chan.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_line_chars(input logic [6:0] erase, input logic [6:0] kill);
		settle();
		wr_en    <= 1'b1;
		wr_index <= REG_ERASE;
		wr_data  <= erase;
		@(posedge clk);
		wr_index <= REG_KILL;
		wr_data  <= kill;
		@(posedge clk);
		wr_en     <= 1'b0;
		erase_now = erase;
		kill_now  = kill;
		settings_used++;
	endtask

	// A well-formed name: random characters, now and then the erase or kill
	// character, ended by CR or LF. Most names are short; some run past the
	// buffer so that both the overrun and a terminator at a full line occur.
	task automatic send_name();
		int len;
		len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(14, 18);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_byte(with_parity($urandom_range(0, 1) ? erase_now : kill_now));
			else
				send_byte(name_char());
		end
		send_byte(with_parity(($urandom_range(0, 2) != 0) ? CH_CR : CH_LF));
	endtask

	// Mostly names, with breaks and bytes of any value as noise. Some names
	// run with no idling on either side.
	task automatic random_phase(input int quota);
		int start;
		int r;
		start = bytes_sent;
		while (bytes_sent - start < quota) begin
			calm <= ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 72)
				send_name();
			else if (r < 80)
				send_byte(with_parity(CH_NUL));
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		byte_chan.valid   = 1'b0;
		byte_chan.rx_byte = 8'd0;
		result_chan.ready = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_ERASE;
		wr_data           = 7'd0;
		bytes_sent        = 0;
		settings_used     = 0;
		stall_left        = 0;
		calm              = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);
		// Fill the line completely, then one more letter: it is dropped, the
		// name completes without CR, and its lowercase flag still counts.
		for (int i = 0; i < NAME_LEN; i++)
			send_byte((i % 2 != 0) ? 8'h4D : 8'hED);
		send_byte(8'h6B);

		random_phase(40);
		// DEL erases, and a kill of zero can never match since zero is a break.
		set_line_chars(7'd127, 7'd0);
		random_phase(40);
		// A letter as erase is still stored; CR as kill stops CR ending a name.
		set_line_chars(7'("x"), CH_CR);
		random_phase(40);
		// LF as erase, so names end on CR or on an overrun only.
		set_line_chars(CH_LF, 7'd1);
		random_phase(35);
		set_line_chars(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
		random_phase(35);
		set_line_chars(ERASE_RESET, KILL_RESET);
		random_phase(25);

		settle();
		repeat (40) @(posedge clk);
		$display("Sent %0d terminal bytes under %0d erase/kill settings.",
			bytes_sent, settings_used + 1);
		$display("Compared %0d results, %0d of them completed names; %0d failures.",
			results_checked, names_done, fail_count);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Far beyond the slowest correct run: every request with its most results,
	// each of them held by the longest stall.
	initial begin
		#(8 * 2000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
